// ===== rtl/core/skmf_pkg.sv =====
// shared types and constants for the sorted key merge filter
// no dependencies; used by the core and the checker
`default_nettype none

package skmf_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int KEY_BITS    = 32;

	localparam int FUNC_W = 2;
	localparam int KEY_W  = 32;
	localparam int ROW_W  = 10;
	localparam int IDX_W  = 32;

	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_PROBE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [KEY_W-1:0]  key;
	} req_t;

	typedef struct packed {
		logic [ROW_W-1:0] filter_row_index;
		logic [IDX_W-1:0] input_row_index;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/sorted_key_merge_filter_core.sv =====
// merge semi-join core: filter key table in ram, scan pointer and counters in flops
// depends on skmf_pkg and skmf_ram
//
// usage:
//   req channel (req_valid / req_stall / req) carries one command per beat:
//   load appends req.key to the filter table (dropped once the table is full),
//   probe scans forward to the first filter key not below req.key and answers
//   on a hit, clear empties the table and zeroes the pointer and probe count.
//   rsp channel (rsp_valid / rsp_stall / rsp) gives one beat per matching probe:
//   the filter row position and the probe's running index since clear.
//   loads, clears and probes that find the pointer at the end never leave idle.
//   a probe issues its first ram read when accepted, then scans, one ram read per
//   cycle while it steps past smaller keys; each row is passed at most once per
//   clear. a hit is decided on the ram read data and registered for rsp.
//   a result waits in an output register; while it is stalled the core keeps
//   taking loads and clears, and a new hit waits in the scan until it drains.
//   reset (arst_n low) empties the table and clears all counters; the ram
//   itself is not cleared, only rows below the fill count are ever read.
`default_nettype none

module sorted_key_merge_filter_core #(
	parameter int TABLE_DEPTH = skmf_pkg::TABLE_DEPTH,
	parameter int KEY_BITS    = skmf_pkg::KEY_BITS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire skmf_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output skmf_pkg::rsp_t     rsp
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	skmf_pkg::state_t state_q, state_nxt;

	logic [CW-1:0]               count_q;
	logic [CW-1:0]               ptr_q;
	logic [CW-1:0]               ptr_inc;
	logic [skmf_pkg::IDX_W-1:0]  probe_cnt_q;
	logic [skmf_pkg::IDX_W-1:0]  probe_idx_q;
	logic [KEY_BITS-1:0]         key_q;
	logic [KEY_BITS-1:0]         key_in;
	logic                        rsp_valid_q;
	skmf_pkg::rsp_t              rsp_q;

	logic                        req_acc;
	logic                        is_load;
	logic                        is_probe;
	logic                        is_clear;
	logic                        ptr_in_range;
	logic                        inc_in_range;
	logic                        out_free;
	logic                        row_lt;
	logic                        row_eq;

	logic                        ram_we;
	logic                        ram_re;
	logic [AW-1:0]               ram_raddr;
	logic [KEY_BITS-1:0]         ram_rdata;
	logic                        ptr_adv;
	logic                        emit;

	assign req_acc      = req_valid && (state_q == skmf_pkg::ST_IDLE);
	assign is_load      = req.func == skmf_pkg::FUNC_LOAD;
	assign is_probe     = req.func == skmf_pkg::FUNC_PROBE;
	assign is_clear     = req.func == skmf_pkg::FUNC_CLEAR;
	assign key_in       = KEY_BITS'(req.key);
	assign ptr_inc      = CW'(ptr_q + CW'(1));
	assign ptr_in_range = ptr_q < count_q;
	assign inc_in_range = ptr_inc < count_q;
	assign out_free     = !rsp_valid_q || !rsp_stall;
	assign row_lt       = ram_rdata < key_q;
	assign row_eq       = ram_rdata == key_q;

	assign req_stall = state_q != skmf_pkg::ST_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			skmf_pkg::ST_IDLE: begin
				if (req_acc && is_probe && ptr_in_range) begin
					state_nxt = skmf_pkg::ST_SCAN;
				end
			end
			skmf_pkg::ST_SCAN: begin
				if (row_lt) begin
					if (!inc_in_range) begin
						state_nxt = skmf_pkg::ST_IDLE;
					end
				end else if (row_eq) begin
					if (out_free) begin
						state_nxt = skmf_pkg::ST_IDLE;
					end
				end else begin
					state_nxt = skmf_pkg::ST_IDLE;
				end
			end
			default: state_nxt = skmf_pkg::ST_IDLE;
		endcase
	end

	// ram access and scan control
	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = ptr_q[AW-1:0];
		ptr_adv   = 1'b0;
		emit      = 1'b0;
		case (state_q)
			skmf_pkg::ST_IDLE: begin
				ram_we = req_acc && is_load && (count_q != CW'(TABLE_DEPTH));
				ram_re = req_acc && is_probe && ptr_in_range;
			end
			skmf_pkg::ST_SCAN: begin
				if (row_lt) begin
					// step past a smaller filter key, fetch the next row if there is one
					ptr_adv   = 1'b1;
					ram_re    = inc_in_range;
					ram_raddr = ptr_inc[AW-1:0];
				end else if (row_eq) begin
					emit = out_free;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	skmf_ram #(
		.WIDTH(KEY_BITS),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata(key_in),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skmf_pkg::ST_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			probe_cnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (req_acc && is_clear) begin
				count_q     <= '0;
				ptr_q       <= '0;
				probe_cnt_q <= '0;
			end else begin
				if (ram_we) begin
					count_q <= CW'(count_q + CW'(1));
				end
				if (ptr_adv) begin
					ptr_q <= ptr_inc;
				end
				if (req_acc && is_probe) begin
					probe_cnt_q <= probe_cnt_q + skmf_pkg::IDX_W'(1);
				end
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc && is_probe) begin
			key_q       <= key_in;
			probe_idx_q <= probe_cnt_q;
		end
		if (emit) begin
			rsp_q.filter_row_index <= skmf_pkg::ROW_W'(ptr_q);
			rsp_q.input_row_index  <= probe_idx_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/skmf_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies; read data holds while no read is issued
`default_nettype none

module skmf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/skmf_chk.sv =====
// port-level checker for sorted_key_merge_filter_core, attached by bind
// depends on skmf_pkg
`default_nettype none

module skmf_chk (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_stall,
	input wire skmf_pkg::req_t req,
	input wire logic           rsp_valid,
	input wire logic           rsp_stall,
	input wire skmf_pkg::rsp_t rsp
);

	logic req_beat;

	assign req_beat = req_valid && !req_stall;

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp beat changed while stalled");

	// loads and clears never produce a result
	a_no_rsp_non_probe: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat && (req.func != skmf_pkg::FUNC_PROBE) && !(rsp_valid && rsp_stall)
		|=> !rsp_valid)
		else $error("result after a non-probe beat");

	// loads and clears never take the core out of idle
	a_non_probe_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat && (req.func != skmf_pkg::FUNC_PROBE) |=> !req_stall)
		else $error("core busy after a non-probe beat");

	// a new result only comes out of a scan, so the core is busy the cycle before
	a_rsp_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid ##1 rsp_valid |-> $past(req_stall))
		else $error("result appeared without a scan");

endmodule

bind sorted_key_merge_filter_core skmf_chk u_skmf_chk (.*);

`default_nettype wire
